FILE: rtl/fdh_pkg.sv
// ----------------------------------------------------------------------------
// fdh_pkg: shared types and constants for the decimate-by-six hold FIR
// Beat payloads, sequencer states, MAC control and the Q1.17 tap table.
// ----------------------------------------------------------------------------
`default_nettype none

package fdh_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = 40;
    localparam int OUT_SHIFT  = 17;
    localparam int COEF_IDX_W = 8;
    localparam int PROTO_LEN  = 72;

    typedef logic [COEF_IDX_W-1:0] t_coef_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] held_sample;
        logic                       new_sample;
    } t_out_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_FLUSH,
        S_ROUND
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
    } t_mac_ctrl;

    // Low-pass prototype times six, Q1.17; taps past the prototype are zero
    function automatic logic signed [COEF_W-1:0] f_coef(input t_coef_idx idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            8'd0:  c = -18'sd164;
            8'd1:  c = -18'sd493;
            8'd2:  c = -18'sd956;
            8'd3:  c = -18'sd1478;
            8'd4:  c = -18'sd1947;
            8'd5:  c = -18'sd2227;
            8'd6:  c = -18'sd2161;
            8'd7:  c = -18'sd1603;
            8'd8:  c = -18'sd439;
            8'd9:  c =  18'sd1400;
            8'd10: c =  18'sd3828;
            8'd11: c =  18'sd6658;
            8'd12: c =  18'sd9643;
            8'd13: c =  18'sd12488;
            8'd14: c =  18'sd14857;
            8'd15: c =  18'sd16414;
            8'd16: c =  18'sd16862;
            8'd17: c =  18'sd15993;
            8'd18: c =  18'sd13744;
            8'd19: c =  18'sd10229;
            8'd20: c =  18'sd5706;
            8'd21: c =  18'sd564;
            8'd22: c = -18'sd4768;
            8'd23: c = -18'sd9598;
            8'd24: c = -18'sd13453;
            8'd25: c = -18'sd15906;
            8'd26: c = -18'sd16699;
            8'd27: c = -18'sd15722;
            8'd28: c = -18'sd13032;
            8'd29: c = -18'sd8863;
            8'd30: c = -18'sd3648;
            8'd31: c =  18'sd2113;
            8'd32: c =  18'sd7761;
            8'd33: c =  18'sd12730;
            8'd34: c =  18'sd16535;
            8'd35: c =  18'sd18834;
            8'd36: c =  18'sd18834;
            8'd37: c =  18'sd16535;
            8'd38: c =  18'sd12730;
            8'd39: c =  18'sd7761;
            8'd40: c =  18'sd2113;
            8'd41: c = -18'sd3648;
            8'd42: c = -18'sd8863;
            8'd43: c = -18'sd13032;
            8'd44: c = -18'sd15722;
            8'd45: c = -18'sd16699;
            8'd46: c = -18'sd15906;
            8'd47: c = -18'sd13453;
            8'd48: c = -18'sd9598;
            8'd49: c = -18'sd4768;
            8'd50: c =  18'sd564;
            8'd51: c =  18'sd5706;
            8'd52: c =  18'sd10229;
            8'd53: c =  18'sd13744;
            8'd54: c =  18'sd15993;
            8'd55: c =  18'sd16862;
            8'd56: c =  18'sd16414;
            8'd57: c =  18'sd14857;
            8'd58: c =  18'sd12488;
            8'd59: c =  18'sd9643;
            8'd60: c =  18'sd6658;
            8'd61: c =  18'sd3828;
            8'd62: c =  18'sd1400;
            8'd63: c = -18'sd439;
            8'd64: c = -18'sd1603;
            8'd65: c = -18'sd2161;
            8'd66: c = -18'sd2227;
            8'd67: c = -18'sd1947;
            8'd68: c = -18'sd1478;
            8'd69: c = -18'sd956;
            8'd70: c = -18'sd493;
            8'd71: c = -18'sd164;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fdh_stream_if.sv
// ----------------------------------------------------------------------------
// fdh_stream_if: valid/ready stream channel
// Carries one payload beat of type T per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdh_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/fdh_cell.sv
// ----------------------------------------------------------------------------
// fdh_cell: one delay-line cell
// Holds one sample and takes its neighbor's value when the chain moves.
// ----------------------------------------------------------------------------
`default_nettype none

module fdh_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_shift,
    input  wire logic signed [fdh_pkg::SAMPLE_W-1:0] i_d,
    output logic signed [fdh_pkg::SAMPLE_W-1:0]      o_q
);

    logic signed [fdh_pkg::SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

FILE: rtl/fdh_mac.sv
// ----------------------------------------------------------------------------
// fdh_mac: shared multiply-accumulate with output rounding
// Registered 16x18 product, 40-bit accumulator, round half up and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module fdh_mac (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire fdh_pkg::t_mac_ctrl                  i_ctrl,
    input  wire logic signed [fdh_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic signed [fdh_pkg::COEF_W-1:0]   i_coef,
    output logic signed [fdh_pkg::SAMPLE_W-1:0]      o_result
);

    localparam int SUM_W = fdh_pkg::ACC_W + 1;
    localparam int Q_W   = SUM_W - fdh_pkg::OUT_SHIFT;

    logic signed [fdh_pkg::PROD_W-1:0] r_prod;
    logic                              r_prod_vld;
    logic signed [fdh_pkg::ACC_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]           w_sum;
    logic signed [Q_W-1:0]             w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_coef;
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + fdh_pkg::ACC_W'(r_prod);
        end
    end

    // (acc + half LSB) >>> OUT_SHIFT, then clamp to 16 bits
    assign w_sum = SUM_W'(r_acc) + (SUM_W'(1) <<< (fdh_pkg::OUT_SHIFT - 1));
    assign w_q   = w_sum[SUM_W-1:fdh_pkg::OUT_SHIFT];

    always_comb begin
        if (w_q > Q_W'(32767)) begin
            o_result = 16'sh7fff;
        end else if (w_q < -Q_W'(32768)) begin
            o_result = 16'sh8000;
        end else begin
            o_result = w_q[fdh_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fir_decimator_by_six_hold.sv
// ----------------------------------------------------------------------------
// fir_decimator_by_six_hold: decimate-by-six low-pass FIR with sample hold
// A row of delay cells rotates past one shared MAC on every sixth input.
//
//   channel  dir  payload                     handshake
//   i_in     in   sample_in (s16)             valid & ready
//   o_out    out  held_sample (s16), new_sample  valid & ready
//
// A non-decimating input is accepted, then its result beat (the held value) is
// staged and handed off to the output register. A decimating input is accepted,
// then the cell row rotates once past the single MAC, then flush, round and
// hand-off follow. No input is accepted while the MAC runs or a result is staged.
// Reset is synchronous and clears the cells, phase and held value at once.
// One result parks in a staging register while o_out stalls; input then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_decimator_by_six_hold #(
    parameter int TAP_COUNT   = 72,
    parameter int DECIM_RATIO = 6
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    fdh_stream_if.sink     i_in,
    fdh_stream_if.source   o_out
);

    localparam int IDX_W   = $clog2(TAP_COUNT);
    localparam int PHASE_W = $clog2(DECIM_RATIO);

    fdh_pkg::t_state   r_state, n_state;
    logic [IDX_W-1:0]  r_tap_idx;
    logic [PHASE_W-1:0] r_phase;
    logic signed [fdh_pkg::SAMPLE_W-1:0] r_held;
    logic                                r_res_vld;
    fdh_pkg::t_out_beat                  r_res;
    logic                                r_out_vld;
    fdh_pkg::t_out_beat                  r_out;

    logic                                w_take;
    logic                                w_fresh;
    logic                                w_shift;
    logic                                w_move;
    fdh_pkg::t_mac_ctrl                  w_mac_ctrl;
    logic signed [fdh_pkg::SAMPLE_W-1:0] w_q [TAP_COUNT];
    logic signed [fdh_pkg::SAMPLE_W-1:0] w_head;
    logic signed [fdh_pkg::SAMPLE_W-1:0] w_result;

    assign w_take  = i_in.valid && i_in.ready;
    assign w_fresh = (r_phase == '0);
    assign w_shift = w_take || (r_state == fdh_pkg::S_MAC);
    assign w_head  = w_take ? i_in.data.sample_in : w_q[TAP_COUNT-1];
    assign w_move  = r_res_vld && (!r_out_vld || o_out.ready);

    // Cell row: head takes the new sample, or the tail while rotating
    for (genvar g = 0; g < TAP_COUNT; g++) begin : g_cell
        if (g == 0) begin : g_head
            fdh_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_head),
                .o_q     (w_q[g])
            );
        end else begin : g_body
            fdh_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_d     (w_q[g-1]),
                .o_q     (w_q[g])
            );
        end
    end

    assign w_mac_ctrl.clear = w_take && w_fresh;
    assign w_mac_ctrl.issue = (r_state == fdh_pkg::S_MAC);

    fdh_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mac_ctrl),
        .i_sample (w_q[TAP_COUNT-1]),
        .i_coef   (fdh_pkg::f_coef(fdh_pkg::t_coef_idx'(r_tap_idx))),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdh_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        case (r_state)
            fdh_pkg::S_IDLE: begin
                i_in.ready = !r_res_vld && i_rst_n;
                if (w_take && w_fresh) begin
                    n_state = fdh_pkg::S_MAC;
                end
            end
            fdh_pkg::S_MAC: begin
                if (r_tap_idx == '0) begin
                    n_state = fdh_pkg::S_FLUSH;
                end
            end
            fdh_pkg::S_FLUSH: begin
                n_state = fdh_pkg::S_ROUND;
            end
            fdh_pkg::S_ROUND: begin
                n_state = fdh_pkg::S_IDLE;
            end
            default: begin
                n_state = fdh_pkg::S_IDLE;
            end
        endcase
    end

    // Tail index walks down so each tap meets its own coefficient
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tap_idx <= IDX_W'(TAP_COUNT - 1);
        end else if (r_state == fdh_pkg::S_MAC) begin
            r_tap_idx <= r_tap_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_take) begin
            r_phase <= (r_phase == PHASE_W'(DECIM_RATIO - 1)) ? '0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (r_state == fdh_pkg::S_ROUND) begin
            r_held <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (w_take && !w_fresh) begin
            r_res_vld <= 1'b1;
        end else if (r_state == fdh_pkg::S_ROUND) begin
            r_res_vld <= 1'b1;
        end else if (w_move) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !w_fresh) begin
            r_res.held_sample <= r_held;
            r_res.new_sample  <= 1'b0;
        end else if (r_state == fdh_pkg::S_ROUND) begin
            r_res.held_sample <= w_result;
            r_res.new_sample  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_move) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/fdh_check.sv
// ----------------------------------------------------------------------------
// fdh_check: port-level checks for the decimate-by-six hold FIR
// Tracks beats in flight and the decimation pattern seen at o_out.
// ----------------------------------------------------------------------------
`default_nettype none

module fdh_check #(
    parameter int DECIM_RATIO = 6
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                i_in_ready,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic signed [fdh_pkg::SAMPLE_W-1:0] i_held_sample,
    input wire logic                                i_new_sample
);

    localparam int PHASE_W = $clog2(DECIM_RATIO);

    logic                                w_in_take;
    logic                                w_out_take;
    logic [1:0]                          r_inflight;
    logic [PHASE_W-1:0]                  r_out_phase;
    logic signed [fdh_pkg::SAMPLE_W-1:0] r_last_held;

    assign w_in_take  = i_in_valid && i_in_ready;
    assign w_out_take = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight  <= '0;
            r_out_phase <= '0;
            r_last_held <= '0;
        end else begin
            r_inflight <= r_inflight + {1'b0, w_in_take} - {1'b0, w_out_take};
            if (w_out_take) begin
                r_out_phase <= (r_out_phase == PHASE_W'(DECIM_RATIO - 1)) ?
                               '0 : r_out_phase + 1'b1;
                r_last_held <= i_held_sample;
            end
        end
    end

    // stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_held_sample) && $stable(i_new_sample))
        else $error("o_out beat changed while stalled");

    // at most one result in the output register and one staged
    a_inflight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight != 2'd3)
        else $error("more than two beats in flight");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != 2'd0)
        else $error("result beat without an accepted input");

    // every DECIM_RATIO-th result is fresh, starting with the first
    a_fresh_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_new_sample == (r_out_phase == '0))
        else $error("new_sample out of decimation phase");

    a_hold_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_new_sample |-> i_held_sample == r_last_held)
        else $error("held_sample changed without a fresh sample");

endmodule

bind fir_decimator_by_six_hold fdh_check #(
    .DECIM_RATIO (DECIM_RATIO)
) u_fdh_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_held_sample (o_out.data.held_sample),
    .i_new_sample  (o_out.data.new_sample)
);

`default_nettype wire
